// ----- hdl/esc_pkg.sv -----
// Package with shared types and constants for the sensor compensation pipeline.
`default_nettype none
package esc_pkg;

  localparam int unsigned NumRegs = 6;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned DivStages = 64;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TEMP   = 3'd0,
    REG_PRESSA = 3'd1,
    REG_PRESSB = 3'd2,
    REG_PRESSC = 3'd3,
    REG_HUMA   = 3'd4,
    REG_HUMB   = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [19:0] raw_temp;
    logic [19:0] raw_press;
    logic [15:0] raw_hum;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] temp_centideg;
    logic [31:0]        press_q24_8;
    logic               press_valid;
    logic [16:0]        hum_q22_10;
  } out_item_t;

  typedef struct packed {
    logic [47:0] tc;
    logic [63:0] pa;
    logic [63:0] pb;
    logic [15:0] pc;
    logic [39:0] ha;
    logic [23:0] hb;
  } cal_t;

  // Pipeline advance control handed to every stage.
  typedef struct packed {
    logic adv;
  } pipe_ctl_t;

endpackage
`default_nettype wire

// ----- hdl/env_sensor_compensation_top.sv -----
// Top level of the pipelined temperature, pressure and humidity compensator.
// Throughput: one measurement set per cycle while no output stall occurs;
// the 64-step divider sets the depth.
// A stall on a valid output freezes the whole pipeline; nothing is lost or repeated.
// Reset clears all valid bits and calibration registers to zero.
`default_nettype none
module env_sensor_compensation_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire esc_pkg::in_item_t            in_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output esc_pkg::out_item_t                out_data_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [esc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [esc_pkg::CfgDataW-1:0] cfg_data_i
);
  import esc_pkg::*;

  cal_t cal;
  pipe_ctl_t ctl;

  esc_cfg_regs u_regs (
    .clk_i, .rst_ni, .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i, .cfg_data_i, .cal_o(cal)
  );

  // Whole pipeline advances unless a finished result is held back.
  assign ctl.adv = !(out_valid_o && out_stall_i);
  assign in_stall_o = !ctl.adv;

  // Calibration fields.
  logic signed [31:0] t1, t2, t3;
  logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic signed [31:0] h1, h2, h3, h4, h5, h6;
  always_comb begin
    t1 = {16'd0, cal.tc[15:0]};
    t2 = {{16{cal.tc[31]}}, cal.tc[31:16]};
    t3 = {{16{cal.tc[47]}}, cal.tc[47:32]};
    p1 = {48'd0, cal.pa[15:0]};
    p2 = {{48{cal.pa[31]}}, cal.pa[31:16]};
    p3 = {{48{cal.pa[47]}}, cal.pa[47:32]};
    p4 = {{48{cal.pa[63]}}, cal.pa[63:48]};
    p5 = {{48{cal.pb[15]}}, cal.pb[15:0]};
    p6 = {{48{cal.pb[31]}}, cal.pb[31:16]};
    p7 = {{48{cal.pb[47]}}, cal.pb[47:32]};
    p8 = {{48{cal.pb[63]}}, cal.pb[63:48]};
    p9 = {{48{cal.pc[15]}}, cal.pc};
    h1 = {24'd0, cal.ha[7:0]};
    h2 = {{16{cal.ha[23]}}, cal.ha[23:8]};
    h3 = {24'd0, cal.ha[31:24]};
    h6 = {{24{cal.ha[39]}}, cal.ha[39:32]};
    h4 = {{20{cal.hb[11]}}, cal.hb[11:0]};
    h5 = {{20{cal.hb[23]}}, cal.hb[23:12]};
  end

  // Stage 1: temperature products.
  logic        v1_q;
  logic signed [31:0] a1_q, dd_q;
  logic [19:0] rp1_q;
  logic [15:0] rh1_q;
  logic signed [31:0] d_c;
  always_comb d_c = {16'd0, in_data_i.raw_temp[19:4]} - t1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (ctl.adv) v1_q <= in_valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (ctl.adv) begin
      a1_q  <= ({15'd0, in_data_i.raw_temp[19:3]} - (t1 <<< 1)) * t2;
      dd_q  <= d_c * d_c;
      rp1_q <= in_data_i.raw_press;
      rh1_q <= in_data_i.raw_hum;
    end
  end

  // Stage 2: fine temperature.
  logic        v2_q;
  logic signed [31:0] tf_q;
  logic [19:0] rp2_q;
  logic [15:0] rh2_q;
  logic signed [31:0] v2c;
  always_comb v2c = ((dd_q >>> 12) * t3) >>> 14;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (ctl.adv) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (ctl.adv) begin
      tf_q  <= (a1_q >>> 11) + v2c;
      rp2_q <= rp1_q;
      rh2_q <= rh1_q;
    end
  end

  // Stage 3: pressure products and humidity first terms.
  logic        v3_q;
  logic signed [31:0] temp3_q, hx3_q, hy3a_q, hy3b_q;
  logic signed [63:0] w1sq_q, w1p5_q, w1p2_q;
  logic [19:0] rp3_q;
  logic signed [63:0] w1c;
  logic signed [32:0] w1n;
  logic signed [65:0] w1sq;
  logic signed [31:0] hv;
  always_comb begin
    w1c  = {{32{tf_q[31]}}, tf_q} - 64'sd128000;
    w1n  = {tf_q[31], tf_q} - 33'sd128000;
    w1sq = w1n * w1n;
    hv   = tf_q - 32'sd76800;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (ctl.adv) v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    if (ctl.adv) begin
      temp3_q <= (tf_q * 32'sd5 + 32'sd128) >>> 8;
      w1sq_q  <= w1sq[63:0];
      w1p5_q  <= w1c * p5;
      w1p2_q  <= w1c * p2;
      rp3_q   <= rp2_q;
      hx3_q   <= (($signed({16'd0, rh2_q}) <<< 14) - (h4 <<< 20) - h5 * hv
                  + 32'sd16384) >>> 15;
      hy3a_q  <= (hv * h6) >>> 10;
      hy3b_q  <= ((hv * h3) >>> 11) + 32'sd32768;
    end
  end

  // Stage 4: pressure var sums, humidity y product.
  logic        v4_q;
  logic signed [31:0] temp4_q, hx4_q, hy4_q;
  logic signed [63:0] w2_4_q, w1_4_q;
  logic [19:0] rp4_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (ctl.adv) v4_q <= v3_q;
  end
  always_ff @(posedge clk_i) begin
    if (ctl.adv) begin
      temp4_q <= temp3_q;
      w2_4_q  <= w1sq_q * p6 + (w1p5_q <<< 17) + (p4 <<< 35);
      w1_4_q  <= ((w1sq_q * p3) >>> 8) + (w1p2_q <<< 12);
      rp4_q   <= rp3_q;
      hx4_q   <= hx3_q;
      hy4_q   <= ((hy3a_q * hy3b_q) >>> 10) + 32'sd2097152;
    end
  end

  // Stage 5: divisor and numerator, humidity y final.
  logic        v5_q;
  logic signed [31:0] temp5_q, hx5_q, hy5_q;
  logic signed [63:0] den5_q, num5_q;
  logic signed [63:0] pp;
  always_comb pp = 64'sd1048576 - {44'd0, rp4_q};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else if (ctl.adv) v5_q <= v4_q;
  end
  always_ff @(posedge clk_i) begin
    if (ctl.adv) begin
      temp5_q <= temp4_q;
      den5_q  <= (((64'sd1 <<< 47) + w1_4_q) * p1) >>> 33;
      num5_q  <= ((pp <<< 31) - w2_4_q) * 64'sd3125;
      hx5_q   <= hx4_q;
      hy5_q   <= (hy4_q * h2 + 32'sd8192) >>> 14;
    end
  end

  // Stage 6: humidity product, operand magnitudes for the divider.
  logic        v6_q;
  logic signed [31:0] temp6_q, hv6_q;
  logic [63:0] un6_q, ud6_q;
  logic        neg6_q, zero6_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else if (ctl.adv) v6_q <= v5_q;
  end
  always_ff @(posedge clk_i) begin
    if (ctl.adv) begin
      temp6_q <= temp5_q;
      hv6_q   <= hx5_q * hy5_q;
      un6_q   <= num5_q[63] ? 64'd0 - num5_q : num5_q;
      ud6_q   <= den5_q[63] ? 64'd0 - den5_q : den5_q;
      neg6_q  <= num5_q[63] ^ den5_q[63];
      zero6_q <= (den5_q == 64'sd0);
    end
  end

  // Stage 7: humidity square term.
  logic        v7_q;
  logic signed [31:0] temp7_q, hv7_q, hsq7_q;
  logic [63:0] un7_q, ud7_q;
  logic        neg7_q, zero7_q;
  logic signed [31:0] hs;
  always_comb hs = hv6_q >>> 15;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v7_q <= 1'b0;
    else if (ctl.adv) v7_q <= v6_q;
  end
  always_ff @(posedge clk_i) begin
    if (ctl.adv) begin
      temp7_q <= temp6_q;
      hv7_q   <= hv6_q;
      hsq7_q  <= (hs * hs) >>> 7;
      un7_q   <= un6_q;
      ud7_q   <= zero6_q ? 64'd1 : ud6_q;
      neg7_q  <= neg6_q;
      zero7_q <= zero6_q;
    end
  end

  // Stage 8: humidity final clamp.
  logic        v8_q;
  logic signed [31:0] temp8_q;
  logic [16:0] hum8_q;
  logic [63:0] un8_q, ud8_q;
  logic        neg8_q, zero8_q;
  logic signed [31:0] hf;
  logic [16:0] hq;
  always_comb begin
    hf = hv7_q - ((hsq7_q * h1) >>> 4);
    if (hf[31]) hq = 17'd0;
    else if (hf > 32'sd419430400) hq = 17'd102400;
    else hq = hf[28:12];
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v8_q <= 1'b0;
    else if (ctl.adv) v8_q <= v7_q;
  end
  always_ff @(posedge clk_i) begin
    if (ctl.adv) begin
      temp8_q <= temp7_q;
      hum8_q  <= hq;
      un8_q   <= un7_q;
      ud8_q   <= ud7_q;
      neg8_q  <= neg7_q;
      zero8_q <= zero7_q;
    end
  end

  // Divider chain: one quotient bit per stage, side data rides along.
  localparam int unsigned SideW = 32 + 17 + 2;
  logic             dv  [DivStages+1];
  logic [63:0]      drem[DivStages+1];
  logic [63:0]      dquo[DivStages+1];
  logic [63:0]      dden[DivStages+1];
  logic [SideW-1:0] dside[DivStages+1];
  assign dv[0]    = v8_q;
  assign drem[0]  = 64'd0;
  assign dquo[0]  = un8_q;
  assign dden[0]  = ud8_q;
  assign dside[0] = {temp8_q, hum8_q, neg8_q, zero8_q};

  for (genvar g = 0; g < DivStages; g++) begin : g_div
    esc_div_stage #(.SideW(SideW)) u_stage (
      .clk_i, .rst_ni, .ctl_i(ctl),
      .vld_i(dv[g]), .rem_i(drem[g]), .quo_i(dquo[g]), .den_i(dden[g]),
      .side_i(dside[g]),
      .vld_o(dv[g+1]), .rem_o(drem[g+1]), .quo_o(dquo[g+1]), .den_o(dden[g+1]),
      .side_o(dside[g+1])
    );
  end

  logic signed [31:0] tempd;
  logic [16:0] humd;
  logic negd, zerod;
  assign {tempd, humd, negd, zerod} = dside[DivStages];

  // Post stage A: signed quotient and the partial products of its a term square.
  logic        va_q;
  logic signed [31:0] tempa_q;
  logic [16:0] huma_q;
  logic        zeroa_q;
  logic signed [63:0] pa_q;
  logic [63:0] sql_q;
  logic [31:0] sqx_q;
  logic signed [63:0] qs, aa;
  always_comb begin
    qs = negd ? 64'd0 - dquo[DivStages] : dquo[DivStages];
    aa = qs >>> 13;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) va_q <= 1'b0;
    else if (ctl.adv) va_q <= dv[DivStages];
  end
  always_ff @(posedge clk_i) begin
    if (ctl.adv) begin
      tempa_q <= tempd;
      huma_q  <= humd;
      zeroa_q <= zerod;
      pa_q    <= qs;
      sql_q   <= {32'd0, aa[31:0]} * {32'd0, aa[31:0]};
      sqx_q   <= aa[63:32] * aa[31:0];
    end
  end

  // Post stage S: the a term square, low 64 bits, from its halves.
  logic        vs_q;
  logic signed [31:0] temps_q;
  logic [16:0] hums_q;
  logic        zeros_q;
  logic signed [63:0] ps_q, asq_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vs_q <= 1'b0;
    else if (ctl.adv) vs_q <= va_q;
  end
  always_ff @(posedge clk_i) begin
    if (ctl.adv) begin
      temps_q <= tempa_q;
      hums_q  <= huma_q;
      zeros_q <= zeroa_q;
      ps_q    <= pa_q;
      asq_q   <= sql_q + {sqx_q[30:0], 33'd0};
    end
  end

  // Post stage B: correction products.
  logic        vb_q;
  logic signed [31:0] tempb_q;
  logic [16:0] humb_q;
  logic        zerob_q;
  logic signed [63:0] pb_q, c1_q, c2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vb_q <= 1'b0;
    else if (ctl.adv) vb_q <= vs_q;
  end
  always_ff @(posedge clk_i) begin
    if (ctl.adv) begin
      tempb_q <= temps_q;
      humb_q  <= hums_q;
      zerob_q <= zeros_q;
      pb_q    <= ps_q;
      c1_q    <= (p9 * asq_q) >>> 25;
      c2_q    <= (p8 * ps_q) >>> 19;
    end
  end

  // Output register: final pressure with saturation, plus temperature and humidity.
  logic signed [63:0] pf;
  logic [31:0] pq;
  always_comb begin
    pf = ((pb_q + c1_q + c2_q) >>> 8) + (p7 <<< 4);
    if (zerob_q || pf[63]) pq = 32'd0;
    else if (pf[63:32] != 32'd0) pq = 32'hFFFF_FFFF;
    else pq = pf[31:0];
  end
  out_item_t out_q;
  logic      ov_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (ctl.adv) ov_q <= vb_q;
  end
  always_ff @(posedge clk_i) begin
    if (ctl.adv) begin
      out_q.temp_centideg <= tempb_q;
      out_q.press_q24_8   <= pq;
      out_q.press_valid   <= !zerob_q;
      out_q.hum_q22_10    <= humb_q;
    end
  end
  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;
endmodule
`default_nettype wire

// ----- hdl/esc_cfg_regs.sv -----
// Calibration register file written through the configuration port.
`default_nettype none
module esc_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [esc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [esc_pkg::CfgDataW-1:0]  cfg_data_i,
  output esc_pkg::cal_t                      cal_o
);
  import esc_pkg::*;

  cal_t cal_q, cal_d;

  assign cfg_ready_o = 1'b1;
  assign cal_o = cal_q;

  // Decode the register index and update the selected word.
  always_comb begin
    cal_d = cal_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_TEMP:   cal_d.tc = cfg_data_i[47:0];
        REG_PRESSA: cal_d.pa = cfg_data_i;
        REG_PRESSB: cal_d.pb = cfg_data_i;
        REG_PRESSC: cal_d.pc = cfg_data_i[15:0];
        REG_HUMA:   cal_d.ha = cfg_data_i[39:0];
        REG_HUMB:   cal_d.hb = cfg_data_i[23:0];
        default:    cal_d = cal_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else begin
      cal_q <= cal_d;
    end
  end
endmodule
`default_nettype wire

// ----- hdl/esc_div_stage.sv -----
// One restoring step of the pipelined unsigned 64-bit divider.
`default_nettype none
module esc_div_stage #(
  parameter int unsigned SideW = 128
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire esc_pkg::pipe_ctl_t ctl_i,
  input  wire logic              vld_i,
  input  wire logic [63:0]       rem_i,
  input  wire logic [63:0]       quo_i,
  input  wire logic [63:0]       den_i,
  input  wire logic [SideW-1:0]  side_i,
  output logic                   vld_o,
  output logic [63:0]            rem_o,
  output logic [63:0]            quo_o,
  output logic [63:0]            den_o,
  output logic [SideW-1:0]       side_o
);
  import esc_pkg::*;

  logic [64:0] trial;
  logic [63:0] rem_d, quo_d;
  logic        vld_q;
  logic [63:0] rem_q, quo_q, den_q;
  logic [SideW-1:0] side_q;

  // Shift in the next dividend bit and subtract if it fits.
  always_comb begin
    trial = {rem_i, quo_i[63]} - {1'b0, den_i};
    if (!trial[64]) begin
      rem_d = trial[63:0];
      quo_d = {quo_i[62:0], 1'b1};
    end else begin
      rem_d = {rem_i[62:0], quo_i[63]};
      quo_d = {quo_i[62:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ctl_i.adv) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      den_q  <= den_i;
      side_q <= side_i;
    end
  end

  assign vld_o = vld_q;
  assign rem_o = rem_q;
  assign quo_o = quo_q;
  assign den_o = den_q;
  assign side_o = side_q;
endmodule
`default_nettype wire

// ----- hdl/esc_checker.sv -----
// Port-level checker for the compensation top level, bound to it.
`default_nettype none
module esc_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire esc_pkg::out_item_t out_data_o
);
  import esc_pkg::*;

  // A held result keeps its payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("held result changed");

  // Input stall only while a result is held back.
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output stall");

  // Humidity stays in its clamped range.
  a_hum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.hum_q22_10 <= 17'd102400)
    else $error("humidity out of range");

  // Invalid pressure reads zero.
  a_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.press_valid |-> out_data_o.press_q24_8 == 32'd0)
    else $error("invalid pressure not zero");
endmodule

bind env_sensor_compensation_top esc_checker u_esc_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_stall_o(in_stall_o),
  .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
);
`default_nettype wire
